// File: src/sbb_pkg.sv
// Shared types, constants and codes of the separable box blur.
`timescale 1ns / 1ps
package sbb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic [10:0] RST_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_HEIGHT = 11'd1024;
  localparam logic [3:0]  RST_RADIUS = 4'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;
  } pix_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic [7:0] chan3_out;
    logic       burst_last;
    logic       frame_last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HSETUP,
    S_ESETUP,
    S_RUN,
    S_FLUSH,
    S_AVG,
    S_WAIT,
    S_OUT
  } state_t;

endpackage

// File: src/sbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sbb_avg.sv
// Four-channel window average: sum times reciprocal of 2r+1, registered.
`timescale 1ns / 1ps
module sbb_avg #(
  parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS
) (
  input  logic                                              clk,
  input  logic                                              start,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                   radius,
  input  logic [3:0][$clog2((2*MAX_RADIUS+1)*255+1)-1:0]    sums,
  output logic [3:0][7:0]                                   avg
);
  import sbb_pkg::*;

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int SW = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int DB = $clog2(2 * MAX_RADIUS + 2);
  localparam int S  = SW + DB;
  localparam int MW = S + 1;
  localparam int PW = SW + MW;

  logic [MW-1:0] recip_tab [MAX_RADIUS+1];
  logic [MW-1:0] recip;
  logic [3:0][PW-1:0] prod;

  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
    localparam logic [MW-1:0] M = MW'(((64'd1 << S) + 64'(2 * g)) / 64'(2 * g + 1));
    assign recip_tab[g] = M;
  end

  assign recip = recip_tab[radius];

  always_ff @(posedge clk) begin
    if (start) begin
      for (int ch = 0; ch < 4; ch++) begin
        prod[ch] <= PW'(sums[ch]) * PW'(recip);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      avg[ch] = prod[ch][S +: 8];
    end
  end

endmodule

// File: src/separable_box_blur_rgba.sv
// Top level of the separable box blur: sequencer, row window and line ring.
`timescale 1ns / 1ps
// Four-channel box blur over a (2r+1) x (2r+1) window with clamped edges,
// pixels in and out in raster order, output r rows behind input; drain
// items flush the last r rows, one pixel each. One item is processed at a
// time. A pixel below column r is only stored. Each row-pass column and
// each output pixel pass setup, run, flush, average and wait, paced by
// the one read port of the row-window RAM and of the line-ring RAM, which
// the sequencer walks one window tap per cycle; an output pixel then holds
// in the output state while results stall. A row-ending pixel runs the row
// pass for each open column; a drain only the column pass. Configuration
// is taken only while idle; a size or radius write restarts the frame.
module separable_box_blur_rgba #(
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pix_valid,
  output logic                             pix_ready,
  input  sbb_pkg::pix_t                    pix_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output sbb_pkg::res_t                    res_data
);
  import sbb_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SLOTS = 2 * MAX_RADIUS + 2;
  localparam int SB    = $clog2(SLOTS);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int II    = ((WW > HW) ? WW : HW) + 1;
  localparam int SW    = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int RLIM_A = (MAX_RADIUS < (MAX_WIDTH - 2) / 2) ? MAX_RADIUS
                                                              : (MAX_WIDTH - 2) / 2;
  localparam int RLIM  = (RLIM_A < (MAX_HEIGHT - 2) / 2) ? RLIM_A : (MAX_HEIGHT - 2) / 2;

  state_t state, state_next;

  logic [10:0] reg_width, reg_height;
  logic [3:0]  reg_radius;
  logic [15:0] r16, w16, h16;
  logic [RW-1:0] eff_r;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  logic [CW-1:0] in_col, out_col, hc;
  logic [SB-1:0] in_slot, y_slot, o_slot, hslot;
  logic [HW-1:0] in_row, out_row;
  logic [31:0]   first_pix;
  logic          mode_e, is_drain;

  logic signed [II-1:0] it_idx, lim_s;
  logic [SB-1:0] it_slot, clamp_slot, rd_slot;
  logic [RW:0]   it_cnt;
  logic          it_lo, it_hi;
  logic          rd_valid, rd_first;
  logic [3:0][SW-1:0] sums;
  logic [31:0]   rd_pix;
  logic [3:0][7:0] avg_pix;

  logic          pix_fire, cfg_fire, out_load;
  logic          row_end, hc_last, pix_ok, x_ge_r, emit_en, drain_ok, out_row_end;
  logic          finish_h, next_h;
  logic [31:0]   pix_word;

  logic          win_we, ring_we;
  logic [31:0]   win_rdata, ring_rdata;

  function automatic logic [SB-1:0] slot_sub(input logic [SB-1:0] a,
                                             input logic [RW-1:0] b);
    logic [SB:0] d;
    d = {1'b0, a} - (SB+1)'(b);
    if ({1'b0, a} < (SB+1)'(b)) begin
      d = d + (SB+1)'(SLOTS);
    end
    return d[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] slot_inc(input logic [SB-1:0] a);
    return (a == SB'(SLOTS - 1)) ? '0 : a + SB'(1);
  endfunction

  always_comb begin
    r16 = 16'(reg_radius);
    if (r16 == 16'd0) begin
      r16 = 16'd1;
    end
    if (r16 > 16'(RLIM)) begin
      r16 = 16'(RLIM);
    end
    w16 = 16'(reg_width);
    if (w16 < (r16 << 1) + 16'd2) begin
      w16 = (r16 << 1) + 16'd2;
    end
    if (w16 > 16'(MAX_WIDTH)) begin
      w16 = 16'(MAX_WIDTH);
    end
    h16 = 16'(reg_height);
    if (h16 < (r16 << 1) + 16'd2) begin
      h16 = (r16 << 1) + 16'd2;
    end
    if (h16 > 16'(MAX_HEIGHT)) begin
      h16 = 16'(MAX_HEIGHT);
    end
  end

  assign eff_r = RW'(r16);
  assign eff_w = WW'(w16);
  assign eff_h = HW'(h16);

  assign pix_word = {pix_data.chan3_in, pix_data.chan2_in, pix_data.chan1_in,
                     pix_data.chan0_in};

  assign pix_fire    = pix_valid & pix_ready;
  assign cfg_fire    = cfg_valid & cfg_ready;
  assign row_end     = (WW'(in_col) == eff_w - WW'(1));
  assign hc_last     = (WW'(hc) == eff_w - WW'(1));
  assign out_row_end = (WW'(out_col) == eff_w - WW'(1));
  assign pix_ok      = (in_row < eff_h);
  assign x_ge_r      = (WW'(in_col) >= WW'(eff_r));
  assign emit_en     = (in_row >= HW'(eff_r));
  assign drain_ok    = (in_row >= eff_h) && (out_row < eff_h);
  assign out_load    = (state == S_OUT) && (!res_valid || res_ready);
  assign finish_h    = ((state == S_WAIT) && !mode_e && !emit_en) ||
                       (out_load && !is_drain);
  assign next_h      = row_end && !hc_last;

  assign lim_s = mode_e ? $signed(II'(eff_h)) - $signed(II'(1))
                        : $signed(II'(eff_w)) - $signed(II'(1));
  assign it_hi = (it_idx > lim_s);
  assign it_lo = mode_e ? (it_idx < $signed(II'(0))) : (it_idx <= $signed(II'(0)));
  assign rd_slot = it_lo ? '0 : (it_hi ? clamp_slot : it_slot);

  assign rd_pix = rd_first ? first_pix : (mode_e ? ring_rdata : win_rdata);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pix_fire) begin
          if (pix_data.kind == KIND_PIXEL) begin
            if (pix_ok && x_ge_r) begin
              state_next = S_HSETUP;
            end
          end else if (drain_ok) begin
            state_next = S_ESETUP;
          end
        end
      end
      S_HSETUP: state_next = S_RUN;
      S_ESETUP: state_next = S_RUN;
      S_RUN: begin
        if (it_cnt == '0) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_AVG;
      S_AVG:   state_next = S_WAIT;
      S_WAIT: begin
        if (mode_e) begin
          state_next = S_OUT;
        end else if (emit_en) begin
          state_next = S_ESETUP;
        end else begin
          state_next = next_h ? S_HSETUP : S_IDLE;
        end
      end
      S_OUT: begin
        if (out_load) begin
          if (is_drain) begin
            state_next = S_IDLE;
          end else begin
            state_next = next_h ? S_HSETUP : S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pix_ready = (state == S_IDLE) && !cfg_valid;
    cfg_ready = (state == S_IDLE);
    win_we    = pix_fire && (pix_data.kind == KIND_PIXEL) && pix_ok;
    ring_we   = (state == S_WAIT) && !mode_e;
  end

  sbb_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_win (
    .clk  (clk),
    .we   (win_we),
    .waddr(in_slot),
    .wdata(pix_word),
    .raddr(rd_slot),
    .rdata(win_rdata)
  );

  sbb_ram #(.WIDTH(32), .DEPTH(SLOTS * (1 << CW))) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr({y_slot, hc}),
    .wdata(avg_pix),
    .raddr({rd_slot, out_col}),
    .rdata(ring_rdata)
  );

  sbb_avg #(.MAX_RADIUS(MAX_RADIUS)) u_avg (
    .clk   (clk),
    .start (state == S_AVG),
    .radius(eff_r),
    .sums  (sums),
    .avg   (avg_pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      reg_width  <= RST_WIDTH;
      reg_height <= RST_HEIGHT;
      reg_radius <= RST_RADIUS;
      in_col     <= '0;
      in_slot    <= '0;
      in_row     <= '0;
      y_slot     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      o_slot     <= '0;
      first_pix  <= '0;
      res_valid  <= 1'b0;
      rd_valid   <= 1'b0;
      rd_first   <= 1'b0;
      mode_e     <= 1'b0;
      is_drain   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == S_RUN);
      rd_first <= (state == S_RUN) && !mode_e && it_lo;

      if (cfg_fire) begin
        case (cfg_index)
          CFG_WIDTH:  reg_width  <= cfg_data;
          CFG_HEIGHT: reg_height <= cfg_data;
          CFG_RADIUS: reg_radius <= cfg_data[3:0];
          default: ;
        endcase
        if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
            cfg_index == CFG_RADIUS) begin
          in_col  <= '0;
          in_slot <= '0;
          in_row  <= '0;
          y_slot  <= '0;
          out_col <= '0;
          out_row <= '0;
          o_slot  <= '0;
        end
      end

      if (pix_fire) begin
        is_drain <= (pix_data.kind == KIND_DRAIN);
        if (pix_data.kind == KIND_PIXEL && pix_ok) begin
          if (in_col == '0) begin
            first_pix <= pix_word;
          end
          if (x_ge_r) begin
            hc    <= in_col - CW'(eff_r);
            hslot <= slot_sub(in_slot, eff_r);
          end else begin
            in_col  <= in_col + CW'(1);
            in_slot <= slot_inc(in_slot);
          end
        end
      end

      case (state)
        S_HSETUP: begin
          mode_e     <= 1'b0;
          it_idx     <= $signed(II'(hc)) - $signed(II'(eff_r));
          it_slot    <= slot_sub(hslot, eff_r);
          it_cnt     <= {eff_r, 1'b0};
          clamp_slot <= '0;
          sums       <= '0;
        end
        S_ESETUP: begin
          mode_e     <= 1'b1;
          it_idx     <= $signed(II'(out_row)) - $signed(II'(eff_r));
          it_slot    <= slot_sub(o_slot, eff_r);
          it_cnt     <= {eff_r, 1'b0};
          clamp_slot <= '0;
          sums       <= '0;
        end
        S_RUN: begin
          it_idx  <= it_idx + $signed(II'(1));
          it_slot <= slot_inc(it_slot);
          it_cnt  <= it_cnt - (RW+1)'(1);
          if (!it_hi && !it_lo) begin
            clamp_slot <= it_slot;
          end
        end
        default: ;
      endcase

      if (rd_valid) begin
        for (int ch = 0; ch < 4; ch++) begin
          sums[ch] <= sums[ch] + SW'(rd_pix[8*ch +: 8]);
        end
      end

      if (finish_h) begin
        if (next_h) begin
          hc    <= hc + CW'(1);
          hslot <= slot_inc(hslot);
        end else if (row_end) begin
          in_col  <= '0;
          in_slot <= '0;
          in_row  <= in_row + HW'(1);
          y_slot  <= slot_inc(y_slot);
        end else begin
          in_col  <= in_col + CW'(1);
          in_slot <= slot_inc(in_slot);
        end
      end

      if (out_load) begin
        res_valid           <= 1'b1;
        res_data.chan0_out  <= avg_pix[0];
        res_data.chan1_out  <= avg_pix[1];
        res_data.chan2_out  <= avg_pix[2];
        res_data.chan3_out  <= avg_pix[3];
        res_data.burst_last <= is_drain || !next_h;
        res_data.frame_last <= (out_row == eff_h - HW'(1)) && out_row_end;
        if (out_row_end) begin
          out_col <= '0;
          if (is_drain && (out_row == eff_h - HW'(1))) begin
            in_col  <= '0;
            in_slot <= '0;
            in_row  <= '0;
            y_slot  <= '0;
            out_row <= '0;
            o_slot  <= '0;
          end else begin
            out_row <= out_row + HW'(1);
            o_slot  <= slot_inc(o_slot);
          end
        end else begin
          out_col <= out_col + CW'(1);
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
